>>> sv/sprite_sheet_header_parser_top_defines.svh
// Assertion macros for the sprite-sheet header parser.
// Used by sprite_sheet_header_parser_top.sv; expects clk and rst in scope.
`ifndef SPRITE_SHEET_HEADER_PARSER_TOP_DEFINES_SVH
`define SPRITE_SHEET_HEADER_PARSER_TOP_DEFINES_SVH

// Condition must hold whenever the antecedent holds
`define SSHP_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Condition must hold in the cycle after the antecedent
`define SSHP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> sv/sshp_pkg.sv
// Shared types and constants for the sprite-sheet header parser.
// No dependencies.
package sshp_pkg;

  // Result kinds (carried on tuser)
  localparam logic [1:0] KIND_FRAME   = 2'd0;
  localparam logic [1:0] KIND_BINHDR  = 2'd1;
  localparam logic [1:0] KIND_PAYLOAD = 2'd2;
  localparam logic [1:0] KIND_ERROR   = 2'd3;

  // Error codes
  localparam logic [3:0] ERR_HEADER     = 4'd0;
  localparam logic [3:0] ERR_ZERO_SHEET = 4'd1;
  localparam logic [3:0] ERR_INF        = 4'd2;
  localparam logic [3:0] ERR_COUNT      = 4'd3;
  localparam logic [3:0] ERR_WIDTHS     = 4'd4;
  localparam logic [3:0] ERR_HEIGHTS    = 4'd5;
  localparam logic [3:0] ERR_FRAME_LIM  = 4'd6;
  localparam logic [3:0] ERR_PACKED_LIM = 4'd7;
  localparam logic [3:0] ERR_BIN        = 4'd8;
  localparam logic [3:0] ERR_UNPACKED   = 4'd9;
  localparam logic [3:0] ERR_BODY_SHORT = 4'd10;

  // Chunk tags, little-endian ASCII
  localparam logic [31:0] TAG_BMP = 32'h3A50_4D42;
  localparam logic [31:0] TAG_INF = 32'h3A46_4E49;
  localparam logic [31:0] TAG_BIN = 32'h3A4E_4942;

  // Bytes of the BIN header counted in the packed total
  localparam logic [31:0] BIN_HDR_BYTES = 32'd5;

  localparam int TABLE_DEPTH = 256;
  localparam int TABLE_AW    = 8;
  localparam int FIFO_DEPTH  = 4;
  localparam int TDATA_W     = 160;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  frame_index;
    logic [15:0] width_out;
    logic [15:0] height_out;
    logic [20:0] frame_pixels;
    logic [19:0] packed_start;
    logic [7:0]  method;
    logic [19:0] unpacked_bytes;
    logic [31:0] compressed_length;
    logic [7:0]  payload_byte;
    logic        last;
    logic [3:0]  error_code;
  } result_t;

  function automatic result_t err_result(input logic [3:0] code);
    result_t r;
    r            = '0;
    r.kind       = KIND_ERROR;
    r.error_code = code;
    return r;
  endfunction

endpackage

>>> sv/sprite_sheet_header_parser_top.sv
// Sprite-sheet resource header parser with a small result queue; one byte per cycle while the queue has room.
// Depends on sshp_pkg and sprite_sheet_header_parser_top_defines.svh.
//
// Usage:
//   Input channel s_*: one resource byte per word on s_tdata[7:0]; s_tlast marks the
//   final byte of a resource, after which the parser rearms for the next one.
//   Output channel m_*: one result per word. m_tuser is the result kind (frame
//   descriptor, BIN header, payload byte, error); m_tlast flags the last payload
//   byte, or a BIN header whose payload is empty.
//   Results are registered into the queue as their bytes are taken and leave in order.
//   Throughput: one byte per cycle while s_tready is high. The parse logic sits
//   between the input port and a four-word result queue; s_tready is high while two
//   queue slots are free, since one byte can produce two results (a result plus an
//   early-end error). A byte that produces two results while the receiver stalls
//   fills the queue faster, and s_tready drops until words drain.
//   Receiver stall: queued results hold on m_tdata; input keeps flowing until fewer
//   than two queue slots are free.
//   Reset: queue emptied, parser armed for a new resource. The width table is not
//   cleared; each entry is written before it is read within a resource.
`include "sprite_sheet_header_parser_top_defines.svh"

module sprite_sheet_header_parser_top #(
  parameter int MAX_IMAGES       = 256,
  parameter int MAX_PIXELS       = 1048576,
  parameter int MAX_PACKED_BYTES = 524288
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [7:0]                   s_tdata,   // [7:0] data_byte
  input  logic                         s_tlast,   // end_of_resource
  output logic                         m_tvalid,
  input  logic                         m_tready,
  // [7:0] frame_index, [23:8] width_out, [39:24] height_out, [60:40] frame_pixels,
  // [80:61] packed_start, [88:81] method, [108:89] unpacked_bytes,
  // [140:109] compressed_length, [148:141] payload_byte, [152:149] error_code,
  // [159:153] zero
  output logic [sshp_pkg::TDATA_W-1:0] m_tdata,
  output logic [1:0]                   m_tuser,   // [1:0] kind
  output logic                         m_tlast    // last
);
  import sshp_pkg::*;

  localparam int IMG_W = $clog2(MAX_IMAGES + 1);
  localparam int PIX_W = $clog2(MAX_PIXELS + 1);
  localparam int PK_W  = $clog2(MAX_PACKED_BYTES + 1);
  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [3:0] {
    S_BMP, S_SW, S_SH, S_INF, S_ISZ, S_CNT, S_WID, S_HGT,
    S_BIN, S_PTOT, S_METH, S_UNP, S_PAY, S_DONE
  } stage_t;

  // Parser state
  stage_t            stage, stage_next;
  logic [1:0]        bif, bif_next;
  logic [31:0]       field_shift, field_shift_next;
  logic [15:0]       sheet_w, sheet_w_next;
  logic [15:0]       sheet_h, sheet_h_next;
  logic [IMG_W-1:0]  image_total, image_total_next;
  logic [IMG_W-1:0]  image_cursor, image_cursor_next;
  logic [PIX_W-1:0]  pixel_sum, pixel_sum_next;
  logic [PK_W-1:0]   packed_sum, packed_sum_next;
  logic [31:0]       bytes_remaining, bytes_remaining_next;
  logic              failed, failed_next;
  logic [7:0]        bin_method, bin_method_next;

  // Width table
  logic [15:0]       width_mem [TABLE_DEPTH];
  logic [15:0]       width_rd;
  logic              tbl_we;

  // Result queue
  result_t           fifo [FIFO_DEPTH];
  logic [PTR_W-1:0]  wr_ptr, rd_ptr;
  logic [CNT_W-1:0]  count;
  logic [1:0]        push_cnt;
  logic              pop;
  result_t           slot0, slot1;

  logic              s_acc;
  logic [31:0]       fval;
  logic              gathering, long_field, field_done;
  logic [31:0]       pc, pk;
  logic [32:0]       pix_tot, pk_tot;
  logic [IMG_W-1:0]  cursor_inc;
  logic              main_vld, trunc_vld;
  result_t           main_res, trunc_res;

  function automatic logic [3:0] trunc_code(input stage_t st);
    logic [3:0] c;
    unique case (st)
      S_BMP, S_SW, S_SH:          c = ERR_HEADER;
      S_INF, S_ISZ, S_CNT:        c = ERR_INF;
      S_WID:                      c = ERR_WIDTHS;
      S_HGT:                      c = ERR_HEIGHTS;
      S_BIN, S_PTOT, S_METH, S_UNP: c = ERR_BIN;
      S_PAY:                      c = ERR_BODY_SHORT;
      default:                    c = ERR_HEADER;
    endcase
    return c;
  endfunction

  assign s_tready = (count <= CNT_W'(FIFO_DEPTH - 2));
  assign s_acc    = s_tvalid && s_tready;

  // Little-endian field assembly
  assign fval       = field_shift | (32'(s_tdata) << {bif, 3'b000});
  assign gathering  = (stage != S_METH) && (stage != S_PAY) && (stage != S_DONE);
  assign long_field = (stage == S_BMP) || (stage == S_INF) || (stage == S_ISZ) ||
                      (stage == S_BIN) || (stage == S_PTOT) || (stage == S_UNP);
  assign field_done = long_field ? (bif == 2'd3) : (bif == 2'd1);

  // Frame size arithmetic
  assign pc         = 32'(width_rd) * 32'(fval[15:0]);
  assign pk         = (pc >> 1) + 32'(pc[0]);
  assign pix_tot    = {1'b0, pc} + 33'(pixel_sum);
  assign pk_tot     = {1'b0, pk} + 33'(packed_sum);
  assign cursor_inc = image_cursor + IMG_W'(1);

  // Per-byte parse step
  always_comb begin
    stage_next           = stage;
    bif_next             = bif;
    field_shift_next     = field_shift;
    sheet_w_next         = sheet_w;
    sheet_h_next         = sheet_h;
    image_total_next     = image_total;
    image_cursor_next    = image_cursor;
    pixel_sum_next       = pixel_sum;
    packed_sum_next      = packed_sum;
    bytes_remaining_next = bytes_remaining;
    failed_next          = failed;
    bin_method_next      = bin_method;
    tbl_we               = 1'b0;
    main_vld             = 1'b0;
    main_res             = '0;
    trunc_vld            = 1'b0;
    trunc_res            = '0;

    if (s_acc) begin
      if (!failed) begin
        if (gathering) begin
          if (field_done) begin
            field_shift_next = '0;
            bif_next         = 2'd0;
          end else begin
            field_shift_next = fval;
            bif_next         = bif + 2'd1;
          end
        end

        unique case (stage)
          S_BMP: begin
            if (field_done) begin
              if (fval != TAG_BMP) begin
                failed_next = 1'b1;
                main_vld    = 1'b1;
                main_res    = err_result(ERR_HEADER);
              end else begin
                stage_next = S_SW;
              end
            end
          end
          S_SW: begin
            if (field_done) begin
              sheet_w_next = fval[15:0];
              stage_next   = S_SH;
            end
          end
          S_SH: begin
            if (field_done) begin
              sheet_h_next = fval[15:0];
              if (sheet_w == 16'd0 || fval[15:0] == 16'd0) begin
                failed_next = 1'b1;
                main_vld    = 1'b1;
                main_res    = err_result(ERR_ZERO_SHEET);
              end else begin
                stage_next = S_INF;
              end
            end
          end
          S_INF: begin
            if (field_done) begin
              if (fval != TAG_INF) begin
                failed_next = 1'b1;
                main_vld    = 1'b1;
                main_res    = err_result(ERR_INF);
              end else begin
                stage_next = S_ISZ;
              end
            end
          end
          S_ISZ: begin
            if (field_done) stage_next = S_CNT;
          end
          S_CNT: begin
            if (field_done) begin
              if (fval[15:0] == 16'd0 || {16'd0, fval[15:0]} > 32'(MAX_IMAGES)) begin
                failed_next = 1'b1;
                main_vld    = 1'b1;
                main_res    = err_result(ERR_COUNT);
              end else begin
                image_total_next  = IMG_W'(fval[15:0]);
                image_cursor_next = '0;
                stage_next        = S_WID;
              end
            end
          end
          S_WID: begin
            if (field_done) begin
              tbl_we = 1'b1;
              if (cursor_inc >= image_total) begin
                image_cursor_next = '0;
                stage_next        = S_HGT;
              end else begin
                image_cursor_next = cursor_inc;
              end
            end
          end
          S_HGT: begin
            if (field_done) begin
              if (width_rd == 16'd0 || fval[15:0] == 16'd0 ||
                  pix_tot > 33'(MAX_PIXELS)) begin
                failed_next = 1'b1;
                main_vld    = 1'b1;
                main_res    = err_result(ERR_FRAME_LIM);
              end else if (pk_tot > 33'(MAX_PACKED_BYTES)) begin
                failed_next = 1'b1;
                main_vld    = 1'b1;
                main_res    = err_result(ERR_PACKED_LIM);
              end else begin
                main_vld              = 1'b1;
                main_res.kind         = KIND_FRAME;
                main_res.frame_index  = 8'(image_cursor);
                main_res.width_out    = width_rd;
                main_res.height_out   = fval[15:0];
                main_res.frame_pixels = 21'(pc);
                main_res.packed_start = 20'(packed_sum);
                pixel_sum_next        = PIX_W'(pix_tot);
                packed_sum_next       = PK_W'(pk_tot);
                image_cursor_next     = cursor_inc;
                if (cursor_inc >= image_total) stage_next = S_BIN;
              end
            end
          end
          S_BIN: begin
            if (field_done) begin
              if (fval != TAG_BIN) begin
                failed_next = 1'b1;
                main_vld    = 1'b1;
                main_res    = err_result(ERR_BIN);
              end else begin
                stage_next = S_PTOT;
              end
            end
          end
          S_PTOT: begin
            if (field_done) begin
              if (fval < BIN_HDR_BYTES) begin
                failed_next = 1'b1;
                main_vld    = 1'b1;
                main_res    = err_result(ERR_BIN);
              end else begin
                bytes_remaining_next = fval - BIN_HDR_BYTES;
                stage_next           = S_METH;
              end
            end
          end
          S_METH: begin
            bin_method_next = s_tdata;
            stage_next      = S_UNP;
          end
          S_UNP: begin
            if (field_done) begin
              if (fval < 32'(packed_sum) || fval > 32'(MAX_PACKED_BYTES)) begin
                failed_next = 1'b1;
                main_vld    = 1'b1;
                main_res    = err_result(ERR_UNPACKED);
              end else begin
                main_vld                   = 1'b1;
                main_res.kind              = KIND_BINHDR;
                main_res.width_out         = sheet_w;
                main_res.height_out        = sheet_h;
                main_res.method            = bin_method;
                main_res.unpacked_bytes    = 20'(fval);
                main_res.compressed_length = bytes_remaining;
                main_res.last              = (bytes_remaining == 32'd0);
                stage_next = (bytes_remaining == 32'd0) ? S_DONE : S_PAY;
              end
            end
          end
          S_PAY: begin
            bytes_remaining_next  = bytes_remaining - 32'd1;
            main_vld              = 1'b1;
            main_res.kind         = KIND_PAYLOAD;
            main_res.payload_byte = s_tdata;
            main_res.last         = (bytes_remaining == 32'd1);
            if (bytes_remaining == 32'd1) stage_next = S_DONE;
          end
          S_DONE: begin
          end
          default: begin
          end
        endcase
      end

      // End of resource: report truncation, then rearm
      if (s_tlast) begin
        if (!failed_next && stage_next != S_DONE) begin
          trunc_vld = 1'b1;
          trunc_res = err_result(trunc_code(stage_next));
        end
        stage_next           = S_BMP;
        bif_next             = 2'd0;
        field_shift_next     = '0;
        sheet_w_next         = '0;
        sheet_h_next         = '0;
        image_total_next     = '0;
        image_cursor_next    = '0;
        pixel_sum_next       = '0;
        packed_sum_next      = '0;
        bytes_remaining_next = '0;
        failed_next          = 1'b0;
        bin_method_next      = '0;
      end
    end
  end

  // Parser registers
  always_ff @(posedge clk) begin
    if (rst) begin
      stage           <= S_BMP;
      bif             <= 2'd0;
      field_shift     <= '0;
      sheet_w         <= '0;
      sheet_h         <= '0;
      image_total     <= '0;
      image_cursor    <= '0;
      pixel_sum       <= '0;
      packed_sum      <= '0;
      bytes_remaining <= '0;
      failed          <= 1'b0;
      bin_method      <= '0;
    end else begin
      stage           <= stage_next;
      bif             <= bif_next;
      field_shift     <= field_shift_next;
      sheet_w         <= sheet_w_next;
      sheet_h         <= sheet_h_next;
      image_total     <= image_total_next;
      image_cursor    <= image_cursor_next;
      pixel_sum       <= pixel_sum_next;
      packed_sum      <= packed_sum_next;
      bytes_remaining <= bytes_remaining_next;
      failed          <= failed_next;
      bin_method      <= bin_method_next;
    end
  end

  // Width table: written in the width run, read at the cursor for heights
  always_ff @(posedge clk) begin
    if (tbl_we) width_mem[TABLE_AW'(image_cursor)] <= fval[15:0];
    width_rd <= width_mem[TABLE_AW'(image_cursor)];
  end

  // Order results for the queue: main result first, then any early-end error
  always_comb begin
    slot0    = main_vld ? main_res : trunc_res;
    slot1    = trunc_res;
    push_cnt = 2'(main_vld) + 2'(trunc_vld);
  end

  assign pop      = m_tvalid && m_tready;
  assign m_tvalid = (count != '0);

  // Result queue storage
  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) fifo[wr_ptr] <= slot0;
    if (push_cnt == 2'd2) fifo[wr_ptr + PTR_W'(1)] <= slot1;
  end

  // Result queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_W'(push_cnt);
      rd_ptr <= rd_ptr + PTR_W'(pop);
      count  <= count + CNT_W'(push_cnt) - CNT_W'(pop);
    end
  end

  // Output word packing
  assign m_tuser = fifo[rd_ptr].kind;
  assign m_tlast = fifo[rd_ptr].last;
  assign m_tdata = {7'd0,
                    fifo[rd_ptr].error_code,
                    fifo[rd_ptr].payload_byte,
                    fifo[rd_ptr].compressed_length,
                    fifo[rd_ptr].unpacked_bytes,
                    fifo[rd_ptr].method,
                    fifo[rd_ptr].packed_start,
                    fifo[rd_ptr].frame_pixels,
                    fifo[rd_ptr].height_out,
                    fifo[rd_ptr].width_out,
                    fifo[rd_ptr].frame_index};

  // Checks
  `SSHP_ASSERT_IMPL(a_push_room, push_cnt != 2'd0, count <= CNT_W'(FIFO_DEPTH - 2), "queue overrun")
  `SSHP_ASSERT_NEXT(a_rearm, s_acc && s_tlast, stage == S_BMP && !failed, "parser did not rearm")
  `SSHP_ASSERT_IMPL(a_pay_count, stage == S_PAY, bytes_remaining != 32'd0, "payload count underflow")
  `SSHP_ASSERT_IMPL(a_two_results, push_cnt == 2'd2, s_tlast && main_vld, "second result without end")

endmodule
